// File: hw/rtl/pmau_pkg.sv
`default_nettype none

package pmau_pkg;

    // payload widths
    localparam int OP_W   = 3;
    localparam int OPND_W = 64;
    localparam int EXP_W  = 63;
    localparam int RES_W  = 30;

    // opcodes
    localparam logic [OP_W-1:0] OP_NEG = 3'd0;
    localparam logic [OP_W-1:0] OP_ADD = 3'd1;
    localparam logic [OP_W-1:0] OP_SUB = 3'd2;
    localparam logic [OP_W-1:0] OP_MUL = 3'd3;
    localparam logic [OP_W-1:0] OP_POW = 3'd4;
    localparam logic [OP_W-1:0] OP_INV = 3'd5;
    localparam logic [OP_W-1:0] OP_DIV = 3'd6;

endpackage

`default_nettype wire

// File: hw/rtl/prime_modulus_arith_unit.sv
`default_nettype none

// for each item both operands are reduced, then negate, add and subtract finish without the multiplier,
//   multiply takes one barrett multiply, power and inverse square-and-multiply, divide one more multiply
// operand reduction is 3 chunks of K bits on the shared barrett multiplier; squarings are
//   skipped while the accumulator is 1, the worst case is a full exponent; unused opcodes give zero
// one item at a time, start is taken again in the done cycle
// reset: rst_n asynchronous, active low, clears sequencer and done; done cannot be stalled
module prime_modulus_arith_unit #(
    parameter int MODULUS       = 1000000007,
    parameter int EXPONENT_BITS = 63
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic        [pmau_pkg::OP_W-1:0]     opcode,
    input  logic signed [pmau_pkg::OPND_W-1:0]   operand_a,
    input  logic signed [pmau_pkg::OPND_W-1:0]   operand_b,
    input  logic        [pmau_pkg::EXP_W-1:0]    exponent,
    output logic                                 done,
    output logic        [pmau_pkg::RES_W-1:0]    residue
);

    import pmau_pkg::*;

    // modulus as a wide constant, its bit length and the barrett factor 4^K / M
    localparam logic [63:0] MOD64 = 64'(MODULUS);
    localparam int          K     = $clog2(MOD64 + 64'd1);
    localparam logic [63:0] MU64  = (64'd1 << (2 * K)) / MOD64;
    localparam int          PW    = 2 * K + 3;

    // exponent register holds either the user exponent or modulus-2
    localparam int EW = (EXPONENT_BITS > K) ? EXPONENT_BITS : K;
    localparam int CW = $clog2(OPND_W + 1);

    // operand magnitude is reduced in K-bit chunks, msb chunk first
    localparam int NCH = (OPND_W + K - 1) / K;
    localparam int MW  = NCH * K;

    localparam logic [K:0]   M_W  = (K + 1)'(MOD64);
    localparam logic [K+1:0] M_X1 = (K + 2)'(MOD64);
    localparam logic [K+1:0] M_X2 = (K + 2)'(MOD64 << 1);
    localparam logic [K+1:0] MU_W = (K + 2)'(MU64);
    localparam logic [EW-1:0] INV_EXP = EW'(MOD64 - 64'd2);

    // sequencer states
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_RED   = 4'd1;
    localparam logic [3:0] S_FIX1  = 4'd2;
    localparam logic [3:0] S_FIX2  = 4'd3;
    localparam logic [3:0] S_OP    = 4'd4;
    localparam logic [3:0] S_SUB2  = 4'd5;
    localparam logic [3:0] S_CSUB  = 4'd6;
    localparam logic [3:0] S_PSTEP = 4'd7;
    localparam logic [3:0] S_MUL1  = 4'd8;
    localparam logic [3:0] S_MUL2  = 4'd9;
    localparam logic [3:0] S_MUL3  = 4'd10;
    localparam logic [3:0] S_MSUB  = 4'd11;
    localparam logic [3:0] S_MCOR  = 4'd12;

    // where a modular multiply returns to
    localparam logic [2:0] RET_SQ  = 3'd0;
    localparam logic [2:0] RET_MB  = 3'd1;
    localparam logic [2:0] RET_FIN = 3'd2;
    localparam logic [2:0] RET_RA  = 3'd3;
    localparam logic [2:0] RET_RB  = 3'd4;

    function automatic logic [K:0] csub(input logic [K:0] v);
        csub = (v >= M_W) ? (v - M_W) : v;
    endfunction

    // control registers
    logic [3:0]    state_reg, state_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [2:0]    ret_reg, ret_next;

    // datapath registers
    logic [OP_W-1:0]   op_reg, op_next;
    logic              sa_reg, sa_next;
    logic              sb_reg, sb_next;
    logic [MW-1:0]     mag_reg, mag_next;
    logic [OPND_W-1:0] mag_b_reg, mag_b_next;
    logic [K:0]        a_reg, a_next;
    logic [K:0]        b_reg, b_next;
    logic [EW-1:0]     e_reg, e_next;
    logic [K:0]        acc_reg, acc_next;
    logic [K-1:0]      base_reg, base_next;
    logic [K-1:0]      x_reg, x_next;
    logic [K-1:0]      y_reg, y_next;
    logic [PW-1:0]     prod_reg, prod_next;
    logic [2*K-1:0]    p_reg, p_next;
    logic [K+1:0]      rr_reg, rr_next;
    logic [RES_W-1:0]  residue_reg, residue_next;

    // combinational helpers
    logic [OPND_W-1:0] mag_a_in, mag_b_in;
    logic [EW-1:0]     e_pow;
    logic [K:0]        ma;
    logic [K+1:0]      mb;
    logic [PW-1:0]     mprod;
    logic [K-1:0]      mres;
    logic              ebit;
    logic [EW-1:0]     e_shift;

    assign mag_a_in = operand_a[OPND_W-1] ? (64'd0 - operand_a) : operand_a;
    assign mag_b_in = operand_b[OPND_W-1] ? (64'd0 - operand_b) : operand_b;
    assign e_pow    = EW'(exponent[EXPONENT_BITS-1:0]);

    // shared multiplier: x*y, then barrett quotient estimate, then quotient times modulus
    always_comb
    begin
        case (state_reg)
            S_MUL2:
            begin
                ma = prod_reg[2*K-1:K-1];
                mb = MU_W;
            end
            S_MUL3:
            begin
                ma = (K + 1)'(prod_reg[K+1 +: K]);
                mb = M_X1;
            end
            default:
            begin
                ma = (K + 1)'(x_reg);
                mb = (K + 2)'(y_reg);
            end
        endcase
    end

    assign mprod = {{(K + 2){1'b0}}, ma} * {{(K + 1){1'b0}}, mb};

    // barrett remainder is below three times the modulus
    always_comb
    begin
        if (rr_reg >= M_X2)
        begin
            mres = K'(rr_reg - M_X2);
        end
        else if (rr_reg >= M_X1)
        begin
            mres = K'(rr_reg - M_X1);
        end
        else
        begin
            mres = K'(rr_reg);
        end
    end

    assign ebit    = e_reg[EW-1];
    assign e_shift = {e_reg[EW-2:0], 1'b0};

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        done_next    = 1'b0;
        cnt_next     = cnt_reg;
        ret_next     = ret_reg;
        op_next      = op_reg;
        sa_next      = sa_reg;
        sb_next      = sb_reg;
        mag_next     = mag_reg;
        mag_b_next   = mag_b_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        e_next       = e_reg;
        acc_next     = acc_reg;
        base_next    = base_reg;
        x_next       = x_reg;
        y_next       = y_reg;
        prod_next    = prod_reg;
        p_next       = p_reg;
        rr_next      = rr_reg;
        residue_next = residue_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next    = opcode;
                    sa_next    = operand_a[OPND_W-1];
                    sb_next    = operand_b[OPND_W-1];
                    mag_next   = MW'(mag_a_in);
                    mag_b_next = mag_b_in;
                    acc_next   = '0;
                    e_next     = (opcode == OP_INV || opcode == OP_DIV) ? INV_EXP : e_pow;
                    cnt_next   = CW'(NCH);
                    ret_next   = RET_RA;
                    state_next = S_RED;
                end
            end

            // fold the next chunk into the running remainder, barrett reduce it
            S_RED:
            begin
                prod_next  = PW'({acc_reg[K-1:0], mag_reg[MW-1 -: K]});
                mag_next   = {mag_reg[MW-K-1:0], {K{1'b0}}};
                cnt_next   = cnt_reg - 1'b1;
                state_next = S_MUL2;
            end

            // negative operands wrap up to a non-negative residue
            S_FIX1:
            begin
                a_next     = sa_reg ? (M_W - a_reg) : a_reg;
                b_next     = sb_reg ? (M_W - b_reg) : b_reg;
                state_next = S_FIX2;
            end

            S_FIX2:
            begin
                a_next     = csub(a_reg);
                b_next     = csub(b_reg);
                state_next = S_OP;
            end

            S_OP:
            begin
                case (op_reg)
                    OP_NEG:
                    begin
                        acc_next   = M_W - a_reg;
                        state_next = S_CSUB;
                    end
                    OP_ADD:
                    begin
                        acc_next   = a_reg + b_reg;
                        state_next = S_CSUB;
                    end
                    OP_SUB:
                    begin
                        acc_next   = M_W - b_reg;
                        state_next = S_SUB2;
                    end
                    OP_MUL:
                    begin
                        x_next     = a_reg[K-1:0];
                        y_next     = b_reg[K-1:0];
                        ret_next   = RET_FIN;
                        state_next = S_MUL1;
                    end
                    OP_POW, OP_INV:
                    begin
                        base_next  = a_reg[K-1:0];
                        acc_next   = (K + 1)'(1);
                        cnt_next   = CW'(EW);
                        state_next = S_PSTEP;
                    end
                    OP_DIV:
                    begin
                        base_next  = b_reg[K-1:0];
                        acc_next   = (K + 1)'(1);
                        cnt_next   = CW'(EW);
                        state_next = S_PSTEP;
                    end
                    default:
                    begin
                        // unused opcode gives zero
                        residue_next = '0;
                        done_next    = 1'b1;
                        state_next   = S_IDLE;
                    end
                endcase
            end

            S_SUB2:
            begin
                acc_next   = a_reg + acc_reg;
                state_next = S_CSUB;
            end

            S_CSUB:
            begin
                residue_next = RES_W'(csub(acc_reg));
                done_next    = 1'b1;
                state_next   = S_IDLE;
            end

            // square-and-multiply, msb first
            S_PSTEP:
            begin
                if (cnt_reg == '0)
                begin
                    if (op_reg == OP_DIV)
                    begin
                        x_next     = a_reg[K-1:0];
                        y_next     = acc_reg[K-1:0];
                        ret_next   = RET_FIN;
                        state_next = S_MUL1;
                    end
                    else
                    begin
                        residue_next = RES_W'(acc_reg);
                        done_next    = 1'b1;
                        state_next   = S_IDLE;
                    end
                end
                else if (acc_reg == (K + 1)'(1))
                begin
                    // squaring one gives one, multiplying one by base gives base
                    if (ebit)
                    begin
                        acc_next = {1'b0, base_reg};
                    end
                    e_next   = e_shift;
                    cnt_next = cnt_reg - 1'b1;
                end
                else
                begin
                    x_next     = acc_reg[K-1:0];
                    y_next     = acc_reg[K-1:0];
                    ret_next   = RET_SQ;
                    state_next = S_MUL1;
                end
            end

            S_MUL1:
            begin
                prod_next  = mprod;
                state_next = S_MUL2;
            end

            S_MUL2:
            begin
                p_next     = prod_reg[2*K-1:0];
                prod_next  = mprod;
                state_next = S_MUL3;
            end

            S_MUL3:
            begin
                prod_next  = mprod;
                state_next = S_MSUB;
            end

            S_MSUB:
            begin
                rr_next    = p_reg[K+1:0] - prod_reg[K+1:0];
                state_next = S_MCOR;
            end

            S_MCOR:
            begin
                case (ret_reg)
                    RET_SQ:
                    begin
                        acc_next = {1'b0, mres};
                        if (ebit)
                        begin
                            x_next     = mres;
                            y_next     = base_reg;
                            ret_next   = RET_MB;
                            state_next = S_MUL1;
                        end
                        else
                        begin
                            e_next     = e_shift;
                            cnt_next   = cnt_reg - 1'b1;
                            state_next = S_PSTEP;
                        end
                    end
                    RET_MB:
                    begin
                        acc_next   = {1'b0, mres};
                        e_next     = e_shift;
                        cnt_next   = cnt_reg - 1'b1;
                        state_next = S_PSTEP;
                    end
                    // last chunk of a done, start on b
                    RET_RA:
                    begin
                        if (cnt_reg == '0)
                        begin
                            a_next   = {1'b0, mres};
                            mag_next = MW'(mag_b_reg);
                            acc_next = '0;
                            cnt_next = CW'(NCH);
                            ret_next = RET_RB;
                        end
                        else
                        begin
                            acc_next = {1'b0, mres};
                        end
                        state_next = S_RED;
                    end
                    RET_RB:
                    begin
                        acc_next = {1'b0, mres};
                        if (cnt_reg == '0)
                        begin
                            b_next     = {1'b0, mres};
                            state_next = S_FIX1;
                        end
                        else
                        begin
                            state_next = S_RED;
                        end
                    end
                    default:
                    begin
                        residue_next = RES_W'(mres);
                        done_next    = 1'b1;
                        state_next   = S_IDLE;
                    end
                endcase
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
            ret_reg   <= RET_FIN;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            cnt_reg   <= cnt_next;
            ret_reg   <= ret_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        sa_reg      <= sa_next;
        sb_reg      <= sb_next;
        mag_reg     <= mag_next;
        mag_b_reg   <= mag_b_next;
        a_reg       <= a_next;
        b_reg       <= b_next;
        e_reg       <= e_next;
        acc_reg     <= acc_next;
        base_reg    <= base_next;
        x_reg       <= x_next;
        y_reg       <= y_next;
        prod_reg    <= prod_next;
        p_reg       <= p_next;
        rr_reg      <= rr_next;
        residue_reg <= residue_next;
    end

    assign busy    = (state_reg != S_IDLE);
    assign done    = done_reg;
    assign residue = residue_reg;

endmodule

`default_nettype wire

// File: hw/rtl/pmau_checker.sv
`default_nettype none

module pmau_checker #(
    parameter int MODULUS = 1000000007
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          start,
    input logic                          busy,
    input logic                          done,
    input logic [pmau_pkg::RES_W-1:0]    residue
);

    // a transfer in makes the unit busy
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted start did not raise busy");

    // the result strobe marks the return to idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("done while still busy");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held longer than one cycle");

    a_fall_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("busy dropped without a result");

    a_residue_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (32'(residue) < 32'(MODULUS)))
        else $error("residue not below modulus");

endmodule

bind prime_modulus_arith_unit pmau_checker #(
    .MODULUS (MODULUS)
) u_pmau_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .done    (done),
    .residue (residue)
);

`default_nettype wire

// File: tb/sv/prime_modulus_arith_unit_tb.sv
`default_nettype none

module prime_modulus_arith_unit_tb;

    import pmau_pkg::*;

    localparam int              MODULUS       = 1000000007;
    localparam int              EXPONENT_BITS = 63;
    localparam longint unsigned MOD_U         = MODULUS;

    // opcode 7 has no meaning, the block answers it with zero
    localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;

    localparam logic [OPND_W-1:0] OPND_MAX   = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [OPND_W-1:0] OPND_MIN   = 64'h8000_0000_0000_0000;
    localparam logic [OPND_W-1:0] OPND_M_ONE = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [EXP_W-1:0]  EXP_ALL    = {EXP_W{1'b1}};

    localparam int RANDOM_ITEMS = 1000;
    // slowest transfer is a power over all exponent bits, plus the longest sender gap;
    // the limit is several times that over every item
    localparam longint CYCLE_LIMIT = 4_000_000;
    // drain time after the last result, longer than the slowest single item
    localparam int TAIL_CYCLES = 800;

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    logic [OP_W-1:0]       opcode;
    logic [OPND_W-1:0]     operand_a;
    logic [OPND_W-1:0]     operand_b;
    logic [EXP_W-1:0]      exponent;
    logic                  done;
    logic [RES_W-1:0]      residue;

    // one directed transfer; pinned rows carry a residue typed in by hand
    typedef struct {
        logic [OP_W-1:0]   op;
        logic [OPND_W-1:0] a;
        logic [OPND_W-1:0] b;
        logic [EXP_W-1:0]  e;
        bit                pinned;
        logic [RES_W-1:0]  want;
    } directed_row_t;

    directed_row_t    directed_rows[$];
    logic [RES_W-1:0] pending_residues[$];
    int               error_count;
    longint           cycle_count;

    prime_modulus_arith_unit #(
        .MODULUS       (MODULUS),
        .EXPONENT_BITS (EXPONENT_BITS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .opcode    (opcode),
        .operand_a (operand_a),
        .operand_b (operand_b),
        .exponent  (exponent),
        .done      (done),
        .residue   (residue)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // residue predictor
    // ------------------------------------------------------------------

    // signed 64-bit operand into 0..MODULUS-1, negatives wrap upward
    function automatic longint unsigned reduce_operand(input logic [OPND_W-1:0] raw);
        longint unsigned mag;
        longint unsigned r;
        if (raw[OPND_W-1])
        begin
            mag = 64'd0 - raw;
            r   = mag % MOD_U;
            return (r != 0) ? MOD_U - r : 64'd0;
        end
        return raw % MOD_U;
    endfunction

    // both factors are below 2^31 so the product fits in 64 bits
    function automatic longint unsigned mul_mod(input longint unsigned x,
                                                input longint unsigned y);
        return (x * y) % MOD_U;
    endfunction

    // square-and-multiply, most significant exponent bit first
    function automatic longint unsigned pow_mod(input longint unsigned base,
                                                input longint unsigned e);
        longint unsigned acc;
        acc = 64'd1 % MOD_U;
        for (int i = 63; i >= 0; i--)
        begin
            acc = mul_mod(acc, acc);
            if (e[i])
                acc = mul_mod(acc, base);
        end
        return acc;
    endfunction

    // fermat inverse, zero maps to zero
    function automatic longint unsigned inverse_mod(input longint unsigned x);
        return pow_mod(x, MOD_U - 2);
    endfunction

    function automatic logic [RES_W-1:0] modular_result(input logic [OP_W-1:0]   op,
                                                        input logic [OPND_W-1:0] raw_a,
                                                        input logic [OPND_W-1:0] raw_b,
                                                        input logic [EXP_W-1:0]  raw_e);
        longint unsigned a;
        longint unsigned b;
        longint unsigned e;
        longint unsigned r;
        a = reduce_operand(raw_a);
        b = reduce_operand(raw_b);
        // only the low EXPONENT_BITS of the exponent count
        e = {1'b0, raw_e} & ((64'd1 << EXPONENT_BITS) - 64'd1);
        case (op)
            OP_NEG: r = (a != 0) ? MOD_U - a : 64'd0;
            OP_ADD:
            begin
                r = a + b;
                if (r >= MOD_U)
                    r -= MOD_U;
            end
            OP_SUB:
            begin
                r = a + (MOD_U - b);
                if (r >= MOD_U)
                    r -= MOD_U;
            end
            OP_MUL:  r = mul_mod(a, b);
            OP_POW:  r = pow_mod(a, e);
            OP_INV:  r = inverse_mod(a);
            OP_DIV:  r = mul_mod(a, inverse_mod(b));
            default: r = 64'd0;
        endcase
        return r[RES_W-1:0];
    endfunction

    // ------------------------------------------------------------------
    // random field generators
    // ------------------------------------------------------------------

    // mix of full-width values, small values, wraps around multiples of the
    // modulus and the signed extremes
    function automatic logic [OPND_W-1:0] random_operand();
        logic [OPND_W-1:0] v;
        case ($urandom_range(0, 5))
            0: v = {$urandom, $urandom};
            1: v = 64'($urandom_range(0, 20));
            2: v = 64'd0 - 64'($urandom_range(1, 20));
            3: v = 64'(MODULUS) * 64'($urandom_range(0, 1000))
                   + 64'($urandom_range(0, 2)) - 64'd1;
            4:
            begin
                case ($urandom_range(0, 2))
                    0:       v = OPND_MIN;
                    1:       v = OPND_MAX;
                    default: v = 64'd0 - 64'(MODULUS);
                endcase
            end
            default: v = 64'($urandom_range(0, 32'h7FFF_FFFF));
        endcase
        return v;
    endfunction

    // full-width exponents are slow, so only one draw in four is full-width
    function automatic logic [EXP_W-1:0] random_exponent();
        logic [EXP_W-1:0] e;
        case ($urandom_range(0, 3))
            0:       e = EXP_W'({$urandom, $urandom});
            1:       e = EXP_W'($urandom_range(0, 70));
            2:       e = EXP_W'(MODULUS - 1 - $urandom_range(0, 1));
            default: e = EXP_W'(1) << $urandom_range(0, EXP_W - 1);
        endcase
        return e;
    endfunction

    // ------------------------------------------------------------------
    // sender
    // ------------------------------------------------------------------

    task automatic add_row(input logic [OP_W-1:0] op, input logic [OPND_W-1:0] a,
                           input logic [OPND_W-1:0] b, input logic [EXP_W-1:0] e,
                           input bit pinned, input logic [RES_W-1:0] want);
        directed_row_t row;
        row = '{op, a, b, e, pinned, want};
        directed_rows = {directed_rows, row};
    endtask

    // present one item and hold it until the transfer; start is only lowered
    // when a gap is taken, so it never toggles twice in one step
    task automatic issue(input logic [OP_W-1:0] op, input logic [OPND_W-1:0] a,
                         input logic [OPND_W-1:0] b, input logic [EXP_W-1:0] e,
                         input bit pinned, input logic [RES_W-1:0] want,
                         input bit may_idle);
        int               gap;
        logic [RES_W-1:0] expected;
        if (may_idle && $urandom_range(0, 99) < 11)
        begin
            // mostly short gaps, now and then one that outlasts the block's work
            gap       = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 150)
                                                    : $urandom_range(1, 4);
            start     <= 1'b0;
            // junk on the payload while start is low must be ignored
            opcode    <= OP_W'($urandom);
            operand_a <= {$urandom, $urandom};
            operand_b <= {$urandom, $urandom};
            exponent  <= EXP_W'({$urandom, $urandom});
            repeat (gap) @(posedge clk);
        end
        start     <= 1'b1;
        opcode    <= op;
        operand_a <= a;
        operand_b <= b;
        exponent  <= e;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        // transfer taken at this edge
        expected = pinned ? want : modular_result(op, a, b, e);
        pending_residues = {pending_residues, expected};
    endtask

    // hold off until every outstanding result has come back
    task automatic wait_drained();
        start <= 1'b0;
        while (pending_residues.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        logic [OP_W-1:0] op;
        bit              quiet;

        error_count = 0;
        rst_n     <= 1'b0;
        start     <= 1'b0;
        opcode    <= '0;
        operand_a <= '0;
        operand_b <= '0;
        exponent  <= '0;

        // directed table: extremes, every opcode and the special cases
        //       op         a                  b                 e            pin   want
        add_row(OP_NEG,    64'd0,             64'd0,            '0,          1'b1, 30'd0);
        add_row(OP_NEG,    64'd1,             64'd0,            '0,          1'b1, 30'(MODULUS - 1));
        add_row(OP_NEG,    OPND_M_ONE,        64'd0,            '0,          1'b1, 30'd1);
        add_row(OP_NEG,    OPND_MAX,          OPND_MIN,         EXP_ALL,     1'b0, '0);
        add_row(OP_ADD,    64'(MODULUS - 1),  64'd1,            '0,          1'b1, 30'd0);
        add_row(OP_ADD,    OPND_MAX,          OPND_MIN,         '0,          1'b0, '0);
        add_row(OP_SUB,    64'd0,             64'd1,            '0,          1'b1, 30'(MODULUS - 1));
        add_row(OP_SUB,    OPND_MIN,          OPND_MAX,         '0,          1'b0, '0);
        add_row(OP_MUL,    OPND_M_ONE,        OPND_M_ONE,       '0,          1'b1, 30'd1);
        add_row(OP_MUL,    64'(MODULUS - 1),  64'(MODULUS - 1), '0,          1'b1, 30'd1);
        add_row(OP_MUL,    OPND_MAX,          OPND_MAX,         '0,          1'b0, '0);
        // zero to the power zero
        add_row(OP_POW,    64'd0,             64'd0,            '0,          1'b1, 30'd1);
        add_row(OP_POW,    64'd2,             64'd0,            '0,          1'b1, 30'd1);
        add_row(OP_POW,    64'd3,             64'd0,            63'd1,       1'b1, 30'd3);
        add_row(OP_POW,    64'(MODULUS),      64'd0,            63'd5,       1'b1, 30'd0);
        add_row(OP_POW,    OPND_MIN,          64'd0,            EXP_ALL,     1'b0, '0);
        // top exponent bit alone
        add_row(OP_POW,    64'd2,             64'd0,            63'd1 << 62, 1'b0, '0);
        // inverse of zero gives zero
        add_row(OP_INV,    64'd0,             64'd0,            '0,          1'b1, 30'd0);
        add_row(OP_INV,    64'd1,             64'd0,            '0,          1'b1, 30'd1);
        add_row(OP_INV,    OPND_M_ONE,        64'd0,            '0,          1'b1, 30'(MODULUS - 1));
        add_row(OP_INV,    OPND_MAX,          64'd0,            '0,          1'b0, '0);
        add_row(OP_DIV,    64'd1,             64'd2,            '0,          1'b1,
                30'((MODULUS + 1) / 2));
        // division by zero, also when b only reduces to zero
        add_row(OP_DIV,    64'd5,             64'd0,            '0,          1'b1, 30'd0);
        add_row(OP_DIV,    64'd6,             64'(MODULUS),     '0,          1'b1, 30'd0);
        add_row(OP_DIV,    OPND_MAX,          OPND_MIN,         '0,          1'b0, '0);
        add_row(OP_UNUSED, OPND_MAX,          OPND_MAX,         EXP_ALL,     1'b1, 30'd0);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            issue(directed_rows[i].op, directed_rows[i].a, directed_rows[i].b,
                  directed_rows[i].e, directed_rows[i].pinned, directed_rows[i].want, 1'b1);

        wait_drained();

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            // no sender idling across a long stretch in the middle
            quiet = (i >= 300) && (i < 500);
            op = ($urandom_range(0, 19) == 0) ? OP_UNUSED : OP_W'($urandom_range(0, 6));
            issue(op, random_operand(), random_operand(), random_exponent(),
                  1'b0, '0, !quiet);
            if (i == 650)
                wait_drained();
        end

        wait_drained();
        // watch for stray done strobes after the last result
        repeat (TAIL_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // ------------------------------------------------------------------
    // result checker: done cannot be held off, one result per strobe
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin
        logic [RES_W-1:0] want;
        if (rst_n && done)
        begin
            if (pending_residues.size() == 0)
            begin
                $display("%0t unexpected result: expected none, actual %0d", $time, residue);
                error_count++;
            end
            else
            begin
                want = pending_residues.pop_front();
                if (residue !== want)
                begin
                    $display("%0t residue mismatch: expected %0d, actual %0d",
                             $time, want, residue);
                    error_count++;
                end
            end
        end
    end

    // watchdog on the whole run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t timeout with %0d results outstanding", $time,
                     pending_residues.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

endmodule

`default_nettype wire

// File: filelist.f
hw/rtl/pmau_pkg.sv
hw/rtl/prime_modulus_arith_unit.sv
hw/rtl/pmau_checker.sv
tb/sv/prime_modulus_arith_unit_tb.sv
